// File: rtl/core/lgpc_pkg.sv
// Package with the types, constants and fixed-point helpers of the Gear predictor-corrector.
`timescale 1ns / 1ps
package lgpc_pkg;

  // One Q16.16 word and the per-particle state row (three axes of y0..y5).
  typedef logic signed [31:0] word_t;
  typedef word_t [5:0] yvec_t;
  typedef yvec_t [2:0] yrow_t;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_INIT = 2'd1,
    ACT_STEP = 2'd2
  } act_e;

  typedef enum logic [2:0] {
    REG_STEP_SIZE = 3'd0,
    REG_HALF_SQ   = 3'd1,
    REG_INV_STEP  = 3'd2,
    REG_DAMPING   = 3'd3,
    REG_NOISE     = 3'd4
  } reg_e;

  localparam logic [30:0] STEP_SIZE_RST = 31'd328;
  localparam logic [30:0] HALF_SQ_RST   = 31'd1;
  localparam logic [30:0] INV_STEP_RST  = 31'd13107200;
  localparam logic [30:0] DAMPING_RST   = 31'd26214400;
  localparam logic [30:0] NOISE_RST     = 31'd0;

  // Gear corrector weights in Q16.16; the weight of y2 is exactly one.
  localparam logic signed [32:0] GEAR_COEF [6] = '{
    33'sd12288, 33'sd45695, 33'sd65536, 33'sd40050, 33'sd10923, 33'sd1092
  };

  // Clamp a wide signed value into 32 bits.
  function automatic word_t sat_w(input logic signed [49:0] v);
    word_t r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Q16.16 product: exact product, add half an LSB, floor, saturate.
  function automatic word_t mulq(input logic signed [32:0] x, input logic signed [32:0] y);
    logic signed [65:0] p;
    logic signed [49:0] q;
    p = 66'(x) * 66'(y);
    p = p + 66'sd32768;
    q = p[65:16];
    return sat_w(q);
  endfunction

  function automatic word_t add_sat(input word_t x, input word_t y);
    logic signed [49:0] s;
    s = 50'(x);
    s = s + 50'(y);
    return sat_w(s);
  endfunction

  function automatic word_t sub_sat(input word_t x, input word_t y);
    logic signed [49:0] s;
    s = 50'(x);
    s = s - 50'(y);
    return sat_w(s);
  endfunction

  // Nordsieck predictor on the corrected vector, each line saturated once.
  function automatic yvec_t predict(input yvec_t c);
    logic signed [49:0] s0;
    logic signed [49:0] s1;
    logic signed [49:0] s2;
    logic signed [49:0] s3;
    logic signed [49:0] s4;
    yvec_t r;
    s0 = 50'(c[0]) + 50'(c[1]) + 50'(c[2]) + 50'(c[3]) + 50'(c[4]) + 50'(c[5]);
    s1 = 50'(c[1]) + 50'sd2 * 50'(c[2]) + 50'sd3 * 50'(c[3]) + 50'sd4 * 50'(c[4]) +
         50'sd5 * 50'(c[5]);
    s2 = 50'(c[2]) + 50'sd3 * 50'(c[3]) + 50'sd6 * 50'(c[4]) + 50'sd10 * 50'(c[5]);
    s3 = 50'(c[3]) + 50'sd4 * 50'(c[4]) + 50'sd10 * 50'(c[5]);
    s4 = 50'(c[4]) + 50'sd5 * 50'(c[5]);
    r[0] = sat_w(s0);
    r[1] = sat_w(s1);
    r[2] = sat_w(s2);
    r[3] = sat_w(s3);
    r[4] = sat_w(s4);
    r[5] = c[5];
    return r;
  endfunction

endpackage

// File: rtl/core/langevin_gear_predictor_corrector.sv
// Langevin fifth-order Gear predictor-corrector with per-particle state memories.
// A step word passes stages 0 to 10 and then the output register before it leaves.
// Throughput: one word per cycle while no word addresses a particle already in the pipeline
// and the output is not held; a word for a particle still in the eleven-stage read-modify-write
// pipeline waits until its write-back has reached the state memory.
// Reset clears the pipeline and the output register and sets the configuration registers to their
// reset values; the state memories are not cleared: a load defines y0..y5 and the inverse mass.
`timescale 1ns / 1ps
module langevin_gear_predictor_corrector #(
  parameter int MAX_PARTICLES = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write channel: the index selects one of the five registers.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [30:0]  cfg_data_i,
  // Input words.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: particle[9:0], a_x, a_y, a_z, b_x, b_y, b_z (32 each),
  // inv_mass[30:0], then seven zero bits.
  input  logic [239:0] s_axis_tdata,
  // tuser: action[1:0].
  input  logic [1:0]   s_axis_tuser,
  // Result words.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
  // damped_fx, damped_fy, damped_fz (32 bits each).
  output logic [287:0] m_axis_tdata
);
  import lgpc_pkg::*;

  localparam int AW   = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int NST  = 11;
  localparam int LAST = NST - 1;

  // Everything one word carries down the pipeline. The field t is the
  // running intermediate product of the current stage.
  typedef struct packed {
    act_e                act;
    logic [AW-1:0]       addr;
    word_t [2:0]         a;
    word_t [2:0]         b;
    logic [30:0]         im;
    word_t [2:0]         t;
    word_t [2:0]         f;
    yrow_t               y;
  } item_t;

  // Configuration registers.
  logic [30:0] step_size_q, half_sq_q, inv_step_q, damping_q, noise_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q <= STEP_SIZE_RST;
      half_sq_q   <= HALF_SQ_RST;
      inv_step_q  <= INV_STEP_RST;
      damping_q   <= DAMPING_RST;
      noise_q     <= NOISE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_STEP_SIZE: step_size_q <= cfg_data_i;
        REG_HALF_SQ:   half_sq_q   <= cfg_data_i;
        REG_INV_STEP:  inv_step_q  <= cfg_data_i;
        REG_DAMPING:   damping_q   <= cfg_data_i;
        REG_NOISE:     noise_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input decode. Words for particles beyond the store or with an unknown
  // action are accepted and dropped at once.
  logic [9:0]    in_particle;
  logic [AW-1:0] in_addr;
  logic          in_keep;
  logic          in_take;
  logic          hazard;
  item_t         in_item;

  assign in_particle = s_axis_tdata[9:0];
  assign in_addr     = AW'(in_particle);
  assign in_keep     = (32'(in_particle) < 32'(MAX_PARTICLES)) &&
                       (s_axis_tuser inside {ACT_LOAD, ACT_INIT, ACT_STEP});

  always_comb begin
    in_item      = '0;
    in_item.act  = act_e'(s_axis_tuser);
    in_item.addr = in_addr;
    in_item.a[0] = s_axis_tdata[41:10];
    in_item.a[1] = s_axis_tdata[73:42];
    in_item.a[2] = s_axis_tdata[105:74];
    in_item.b[0] = s_axis_tdata[137:106];
    in_item.b[1] = s_axis_tdata[169:138];
    in_item.b[2] = s_axis_tdata[201:170];
    in_item.im   = s_axis_tdata[232:202];
  end

  // Pipeline registers and per-stage handshake.
  item_t            pipe_q [NST];
  item_t            nxt    [NST];
  logic [NST-1:0]   valid_q;
  logic [NST-1:0]   move;
  logic [NST-1:0]   free;
  logic             out_space;
  logic             out_valid_q;
  logic [287:0]     out_data_q;
  logic             mem_we;
  logic             last_step;

  assign out_space = !out_valid_q || m_axis_tready;
  assign last_step = (pipe_q[LAST].act == ACT_STEP);

  // A stage can take a new word when it is empty or its word moves on.
  // Loads and inits leave the last stage without touching the output.
  always_comb begin
    move[LAST] = valid_q[LAST] && (!last_step || out_space);
    free[LAST] = !valid_q[LAST] || move[LAST];
    for (int i = LAST - 1; i >= 0; i--) begin
      move[i] = valid_q[i] && free[i+1];
      free[i] = !valid_q[i] || move[i];
    end
  end

  // Interlock: a word may not read a particle whose write-back is still
  // in flight, including the write that happens at this very edge.
  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < NST; i++) begin
      if (valid_q[i] && (pipe_q[i].addr == in_addr)) begin
        hazard = 1'b1;
      end
    end
  end

  assign s_axis_tready = free[0] && !(in_keep && hazard);
  assign in_take       = s_axis_tvalid && s_axis_tready && in_keep;
  assign mem_we        = move[LAST];

  // State memories: one row of y0..y5 for all three axes, and the inverse mass.
  yrow_t         state_mem [MAX_PARTICLES];
  logic [30:0]   mass_mem  [MAX_PARTICLES];
  yrow_t         rd_row_q;
  logic [30:0]   rd_mass_q;
  logic [AW-1:0] rd_addr;

  // The read follows the word into stage 0 and is repeated while it waits there.
  assign rd_addr = in_take ? in_addr : pipe_q[0].addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      state_mem[pipe_q[LAST].addr] <= pipe_q[LAST].y;
      mass_mem[pipe_q[LAST].addr]  <= pipe_q[LAST].im;
    end
    rd_row_q  <= state_mem[rd_addr];
    rd_mass_q <= mass_mem[rd_addr];
  end

  // Stage logic: each stage holds at most one multiplication per axis but stage 8, the corrector, with five.
  always_comb begin
    item_t it;
    nxt[0] = in_item;
    for (int k = 0; k < LAST; k++) begin
      it = pipe_q[k];
      case (k)
        0: begin
          if (it.act != ACT_LOAD) begin
            it.y  = rd_row_q;
            it.im = rd_mass_q;
          end
          for (int ax = 0; ax < 3; ax++) begin
            it.t[ax] = mulq(33'(it.b[ax]),
                            (it.act == ACT_LOAD) ? 33'(step_size_q) : 33'(noise_q));
          end
        end
        1: begin
          for (int ax = 0; ax < 3; ax++) begin
            if (it.act == ACT_LOAD) begin
              it.y[ax][0]   = it.a[ax];
              it.y[ax][1]   = it.t[ax];
              it.y[ax][5:2] = '0;
            end else begin
              it.t[ax] = mulq(33'(it.t[ax]), 33'(it.im));
            end
          end
        end
        2: begin
          for (int ax = 0; ax < 3; ax++) begin
            if (it.act == ACT_STEP) begin
              it.y[ax][1] = add_sat(it.y[ax][1], it.t[ax]);
            end
          end
        end
        3: begin
          for (int ax = 0; ax < 3; ax++) begin
            it.t[ax] = mulq(33'(damping_q), 33'(it.y[ax][1]));
          end
        end
        4: begin
          for (int ax = 0; ax < 3; ax++) begin
            it.f[ax] = (it.act == ACT_STEP) ? sub_sat(it.a[ax], it.t[ax]) : it.a[ax];
          end
        end
        5: begin
          for (int ax = 0; ax < 3; ax++) begin
            it.t[ax] = mulq(33'(it.f[ax]), 33'(it.im));
          end
        end
        6: begin
          for (int ax = 0; ax < 3; ax++) begin
            it.t[ax] = mulq(33'(it.t[ax]), 33'(half_sq_q));
          end
        end
        7: begin
          for (int ax = 0; ax < 3; ax++) begin
            if (it.act == ACT_INIT) begin
              it.y[ax][2] = it.t[ax];
            end else begin
              it.t[ax] = sub_sat(it.y[ax][2], it.t[ax]);
            end
          end
        end
        8: begin
          if (it.act == ACT_STEP) begin
            for (int ax = 0; ax < 3; ax++) begin
              for (int j = 0; j < 6; j++) begin
                if (j == 2) begin
                  it.y[ax][j] = sub_sat(it.y[ax][j], it.t[ax]);
                end else begin
                  it.y[ax][j] = sub_sat(it.y[ax][j], mulq(GEAR_COEF[j], 33'(it.t[ax])));
                end
              end
            end
          end
        end
        9: begin
          if (it.act == ACT_STEP) begin
            for (int ax = 0; ax < 3; ax++) begin
              it.y[ax] = predict(it.y[ax]);
            end
          end
        end
        default: ;
      endcase
      nxt[k+1] = it;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (free[0]) begin
        valid_q[0] <= in_take;
      end
      for (int i = 1; i < NST; i++) begin
        if (free[i]) begin
          valid_q[i] <= move[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NST; i++) begin
      if (free[i]) begin
        pipe_q[i] <= nxt[i];
      end
    end
  end

  // Output register: the velocity scaling is the last multiplication.
  logic [287:0] out_data_d;

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      out_data_d[32*ax +: 32]       = pipe_q[LAST].y[ax][0];
      out_data_d[96 + 32*ax +: 32]  = mulq(33'(pipe_q[LAST].y[ax][1]), 33'(inv_step_q));
      out_data_d[192 + 32*ax +: 32] = pipe_q[LAST].f[ax];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_space) begin
      out_valid_q <= move[LAST] && last_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move[LAST] && last_step) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // The interlock keeps every particle at most once in the pipeline.
  logic dup_front;

  always_comb begin
    dup_front = 1'b0;
    for (int i = 1; i < NST; i++) begin
      if (valid_q[0] && valid_q[i] && (pipe_q[i].addr == pipe_q[0].addr)) begin
        dup_front = 1'b1;
      end
    end
  end

  a_single_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dup_front)
    else $error("particle present twice in the pipeline");

  a_step_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[LAST] && last_step && m_axis_tvalid && !m_axis_tready |=> valid_q[LAST])
    else $error("step word left the last stage while the output was blocked");

  a_out_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(mem_we))
    else $error("result word appeared without a state write-back");

endmodule
